// ----- rtl/core/ffde_pkg.sv -----
// shared types, codes and tables of the conserved-to-primitive converter
package ffde_pkg;

	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_CONV,
		KIND_ZDET
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_ZDET,
		ST_ZQ,
		ST_SAT
	} status_t;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic sat;
	} alu_rsp_t;

	localparam int KindBits = 2;
	localparam int IdxBits  = 3;
	localparam int MetricEntries = 6;

	// symmetric metric: row, column to entry xx,xy,xz,yy,yz,zz
	function automatic logic [2:0] metric_pos(input logic [1:0] i, input logic [1:0] j);
		logic [2:0] p;
		unique case ({i, j})
			4'b0000: p = 3'd0;
			4'b0001, 4'b0100: p = 3'd1;
			4'b0010, 4'b1000: p = 3'd2;
			4'b0101: p = 3'd3;
			4'b0110, 4'b1001: p = 3'd4;
			4'b1010: p = 3'd5;
			default: p = 3'd0;
		endcase
		return p;
	endfunction

	function automatic logic [1:0] next3(input logic [1:0] i);
		return (i == 2'd2) ? 2'd0 : i + 2'd1;
	endfunction

endpackage

// ----- rtl/core/ffde_front.sv -----
// input stage: accepts words, drops bad loads, flags zero determinant
module ffde_front import ffde_pkg::*; #(
	parameter int W  = 48,
	parameter int DW = 5 + 7 * 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              command,
	input  logic [2:0]        metric_index,
	input  logic [W-1:0]      metric_value,
	input  logic [W-1:0]      det_factor,
	input  logic [6*W-1:0]    cons,
	output logic              push,
	input  logic              full,
	output logic [DW-1:0]     push_data
);

	logic          valid_q;
	logic [DW-1:0] ent_q;
	kind_t         kind;
	logic          keep;

	always_comb begin
		if (!command) begin
			kind = KIND_LOAD;
		end else if (det_factor == '0) begin
			kind = KIND_ZDET;
		end else begin
			kind = KIND_CONV;
		end
		// loads beyond the last entry do nothing
		keep = command || (metric_index < 3'(MetricEntries));
	end

	assign push      = valid_q && !full;
	assign in_ready  = !valid_q || !full;
	assign push_data = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_q <= keep;
				ent_q   <= {cons, (command ? det_factor : metric_value), metric_index, kind};
			end else if (push) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/ffde_queue.sv -----
// two-entry queue between front and back
module ffde_queue #(
	parameter int DW = 341
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	output logic          full,
	input  logic          pop,
	output logic          pop_valid,
	output logic [DW-1:0] pop_data
);

	logic [DW-1:0] mem_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				mem_q[wr_q] <= push_data;
				wr_q        <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");

endmodule

// ----- rtl/core/ffde_alu.sv -----
// shared multiplier and restoring divider with rounding and saturation
module ffde_alu import ffde_pkg::*; #(
	parameter int W = 48,
	parameter int F = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  alu_req_t     req,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output alu_rsp_t     rsp,
	output logic [W-1:0] res
);

	localparam int H  = (W + 1) / 2;
	localparam int PW = 4 * H;
	localparam int NW = W + F;
	localparam int XW = (PW > NW) ? PW : NW;
	localparam int CW = $clog2(NW);

	typedef enum logic [1:0] {
		A_IDLE,
		A_RUN,
		A_FIN
	} astate_t;

	astate_t       st_q;
	alu_op_t       op_q;
	logic          neg_q;
	logic [W-1:0]  xa_q;
	logic [W-1:0]  yb_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] acc_q;
	logic [NW-1:0] num_q;
	logic [W-1:0]  rem_q;
	logic          done_q;
	logic          sat_q;
	logic [W-1:0]  res_q;

	logic [W-1:0]   ma, mb;
	logic [H-1:0]   xl, xh, yl, yh, sx, sy;
	logic [2*H-1:0] pp;
	logic [PW-1:0]  ppx;
	logic [1:0]     sh;
	logic [W:0]     rem2, diff;
	logic           ge;
	logic [PW-1:0]  rnd;
	logic [XW-1:0]  magx, lim;
	logic           over;
	logic [W-1:0]   val, rv;
	logic [CW-1:0]  last;

	always_comb begin
		ma = a[W-1] ? -a : a;
		mb = b[W-1] ? -b : b;
		xl = xa_q[H-1:0];
		xh = H'(xa_q >> H);
		yl = yb_q[H-1:0];
		yh = H'(yb_q >> H);
		sx = cnt_q[1] ? xh : xl;
		sy = cnt_q[0] ? yh : yl;
		pp = sx * sy;
		sh = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
		unique case (sh)
			2'd0: ppx = PW'(pp);
			2'd1: ppx = PW'(pp) << H;
			default: ppx = PW'(pp) << (2 * H);
		endcase
		rem2 = {rem_q, num_q[NW-1]};
		ge   = rem2 >= {1'b0, yb_q};
		diff = rem2 - {1'b0, yb_q};
		last = (op_q == OP_MUL) ? CW'(3) : CW'(NW - 1);
		// round half away from zero on the magnitude
		rnd  = acc_q + (PW'(1) << (F - 1));
		magx = (op_q == OP_MUL) ? XW'(rnd >> F) : XW'(num_q);
		lim  = neg_q ? (XW'(1) << (W - 1)) : ((XW'(1) << (W - 1)) - XW'(1));
		over = magx > lim;
		val  = over ? lim[W-1:0] : magx[W-1:0];
		rv   = neg_q ? -val : val;
	end

	assign rsp = '{done: done_q, sat: sat_q};
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= A_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				A_IDLE: begin
					if (req.start) begin
						op_q  <= req.op;
						neg_q <= a[W-1] ^ b[W-1];
						xa_q  <= ma;
						yb_q  <= mb;
						cnt_q <= '0;
						acc_q <= '0;
						num_q <= NW'(ma) << F;
						rem_q <= '0;
						st_q  <= A_RUN;
					end
				end
				A_RUN: begin
					if (op_q == OP_MUL) begin
						acc_q <= acc_q + ppx;
					end else begin
						rem_q <= ge ? diff[W-1:0] : rem2[W-1:0];
						num_q <= {num_q[NW-2:0], ge};
					end
					if (cnt_q == last) begin
						st_q <= A_FIN;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				A_FIN: begin
					res_q  <= rv;
					sat_q  <= over;
					done_q <= 1'b1;
					st_q   <= A_IDLE;
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/ffde_back.sv -----
// sequencer: metric store, operand selection, output register
module ffde_back import ffde_pkg::*; #(
	parameter int W  = 48,
	parameter int F  = 32,
	parameter int DW = 5 + 7 * 48
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ent_valid,
	input  logic [DW-1:0]   ent,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [6*W+1:0]  out_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIVB,
		S_LOW,
		S_QS,
		S_CRA,
		S_CRB,
		S_DQ,
		S_DD,
		S_OUT
	} state_t;

	state_t         state_q;
	logic           pend_q;
	logic [W-1:0]   g_q   [MetricEntries];
	logic [W-1:0]   c_q   [6];
	logic [W-1:0]   r_q   [6];
	logic [W-1:0]   low_q [3];
	logic [W-1:0]   e_q   [3];
	logic [W-1:0]   d_q, q_q, acc_q, m1_q, t_q;
	logic [2:0]     k_q;
	logic [1:0]     i_q, j_q;
	logic           sat_q, zq_q;
	logic           out_valid_q;
	logic [6*W+1:0] out_q;

	kind_t        kind;
	logic [2:0]   idx;
	logic [W-1:0] w0;
	logic         out_free;
	alu_req_t     req;
	alu_rsp_t     rsp;
	logic [W-1:0] op_a, op_b, alu_res;
	logic [1:0]   ia, ib;
	logic [W:0]   addr, subr;

	function automatic logic [W:0] sadd(input logic [W-1:0] x, input logic [W-1:0] y,
			input logic sub);
		logic [W:0]   s;
		logic [W-1:0] v;
		logic         ov;
		s  = sub ? ({x[W-1], x} - {y[W-1], y}) : ({x[W-1], x} + {y[W-1], y});
		ov = s[W] != s[W-1];
		v  = s[W-1:0];
		if (ov) begin
			v = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end
		return {ov, v};
	endfunction

	assign kind     = kind_t'(ent[KindBits-1:0]);
	assign idx      = ent[KindBits +: IdxBits];
	assign w0       = ent[KindBits+IdxBits +: W];
	assign out_free = !out_valid_q || out_ready;
	assign pop      = ent_valid && (state_q == S_IDLE) && ((kind != KIND_ZDET) || out_free);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		ia = next3(i_q);
		ib = next3(ia);
		req.start = 1'b0;
		req.op    = OP_MUL;
		op_a      = '0;
		op_b      = '0;
		unique case (state_q)
			S_DIVB: begin
				req.op = OP_DIV;
				op_a   = c_q[k_q];
				op_b   = d_q;
			end
			S_LOW: begin
				op_a = g_q[metric_pos(i_q, j_q)];
				op_b = r_q[{1'b0, j_q}];
			end
			S_QS: begin
				op_a = low_q[i_q];
				op_b = r_q[{1'b0, i_q}];
			end
			S_CRA: begin
				op_a = low_q[ia];
				op_b = r_q[3'd3 + {1'b0, ib}];
			end
			S_CRB: begin
				op_a = low_q[ib];
				op_b = r_q[3'd3 + {1'b0, ia}];
			end
			S_DQ: begin
				req.op = OP_DIV;
				op_a   = t_q;
				op_b   = q_q;
			end
			S_DD: begin
				req.op = OP_DIV;
				op_a   = t_q;
				op_b   = d_q;
			end
			default: begin
			end
		endcase
		if (state_q != S_IDLE && state_q != S_OUT) begin
			req.start = !pend_q;
		end
		addr = sadd(acc_q, alu_res, 1'b0);
		subr = sadd(m1_q, alu_res, 1'b1);
	end

	ffde_alu #(.W(W), .F(F)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.a      (op_a),
		.b      (op_b),
		.rsp    (rsp),
		.res    (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (req.start) begin
				pend_q <= 1'b1;
			end
			if (rsp.done) begin
				pend_q <= 1'b0;
				sat_q  <= sat_q | rsp.sat;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						unique case (kind)
							KIND_LOAD: g_q[idx] <= w0;
							KIND_ZDET: begin
								out_valid_q <= 1'b1;
								out_q       <= {ST_ZDET, {(6*W){1'b0}}};
							end
							default: begin
								d_q   <= w0;
								for (int n = 0; n < 6; n++) begin
									c_q[n] <= ent[KindBits+IdxBits+W+n*W +: W];
								end
								k_q     <= 3'd0;
								sat_q   <= 1'b0;
								zq_q    <= 1'b0;
								state_q <= S_DIVB;
							end
						endcase
					end
				end
				S_DIVB: begin
					if (rsp.done) begin
						r_q[k_q] <= alu_res;
						if (k_q == 3'd5) begin
							i_q     <= 2'd0;
							j_q     <= 2'd0;
							acc_q   <= '0;
							state_q <= S_LOW;
						end else begin
							k_q <= k_q + 3'd1;
						end
					end
				end
				S_LOW: begin
					if (rsp.done) begin
						sat_q <= sat_q | rsp.sat | addr[W];
						if (j_q == 2'd2) begin
							low_q[i_q] <= addr[W-1:0];
							acc_q      <= '0;
							j_q        <= 2'd0;
							if (i_q == 2'd2) begin
								i_q     <= 2'd0;
								state_q <= S_QS;
							end else begin
								i_q <= i_q + 2'd1;
							end
						end else begin
							acc_q <= addr[W-1:0];
							j_q   <= j_q + 2'd1;
						end
					end
				end
				S_QS: begin
					if (rsp.done) begin
						sat_q <= sat_q | rsp.sat | addr[W];
						acc_q <= addr[W-1:0];
						if (i_q == 2'd2) begin
							q_q <= addr[W-1:0];
							i_q <= 2'd0;
							if (addr[W-1:0] == '0) begin
								zq_q <= 1'b1;
								for (int n = 0; n < 3; n++) begin
									e_q[n] <= '0;
								end
								state_q <= S_OUT;
							end else begin
								state_q <= S_CRA;
							end
						end else begin
							i_q <= i_q + 2'd1;
						end
					end
				end
				S_CRA: begin
					if (rsp.done) begin
						m1_q    <= alu_res;
						state_q <= S_CRB;
					end
				end
				S_CRB: begin
					if (rsp.done) begin
						sat_q   <= sat_q | rsp.sat | subr[W];
						t_q     <= subr[W-1:0];
						state_q <= S_DQ;
					end
				end
				S_DQ: begin
					if (rsp.done) begin
						t_q     <= alu_res;
						state_q <= S_DD;
					end
				end
				S_DD: begin
					if (rsp.done) begin
						e_q[i_q] <= alu_res;
						if (i_q == 2'd2) begin
							state_q <= S_OUT;
						end else begin
							i_q     <= i_q + 2'd1;
							state_q <= S_CRA;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q <= {(zq_q ? ST_ZQ : (sat_q ? ST_SAT : ST_OK)),
							r_q[2], r_q[1], r_q[0], e_q[2], e_q[1], e_q[0]};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) rsp.done |-> pend_q)
		else $error("arithmetic result without a pending request");

	assert property (@(posedge clk) disable iff (!arst_n) (state_q == S_IDLE) |-> !pend_q)
		else $error("sequencer idle with arithmetic still pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q[6*W+1:6*W] == ST_ZDET)) |-> (out_q[6*W-1:0] == '0))
		else $error("zero determinant result carries nonzero fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q[6*W+1:6*W] == ST_ZQ)) |-> (out_q[3*W-1:0] == '0))
		else $error("zero field strength result carries nonzero electric field");

endmodule

// ----- rtl/core/ffde_conserved_to_primitive.sv -----
// top level of the force-free conserved-to-primitive converter
// A load word writes one metric entry (xx,xy,xz,yy,yz,zz); indexes six and seven are
// dropped. A convert word with a zero determinant factor gives its status word with no
// arithmetic. Any other convert word runs on one shared arithmetic unit under a
// sequencer: twelve divisions (one quotient bit a cycle) and eighteen multiplies (four
// half-word partial products each); with zero field strength the last six divisions and
// six multiplies are skipped. A two-word queue parts the input register from the sequencer,
// and a result register holds the finished word while the next one is taken in.
module ffde_conserved_to_primitive import ffde_pkg::*; #(
	parameter int WORD_BITS = 48,
	parameter int FRAC_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// metric_index, metric_value, det_factor, cons_b1..3, cons_s1..3, zero fill
	input  logic [((3+8*WORD_BITS+7)/8)*8-1:0] s_tdata,
	// command
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// field_e1..3, field_b1..3, status, zero fill
	output logic [((6*WORD_BITS+2+7)/8)*8-1:0] m_tdata
);

	localparam int W   = WORD_BITS;
	localparam int DW  = KindBits + IdxBits + 7 * W;
	localparam int OTW = ((6 * W + 2 + 7) / 8) * 8;

	logic           push, full, pop, qv;
	logic [DW-1:0]  push_data, pop_data;
	logic [6*W+1:0] back_data;

	ffde_front #(.W(W), .DW(DW)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.command      (s_tuser),
		.metric_index (s_tdata[2:0]),
		.metric_value (s_tdata[3 +: W]),
		.det_factor   (s_tdata[3+W +: W]),
		.cons         (s_tdata[3+2*W +: 6*W]),
		.push         (push),
		.full         (full),
		.push_data    (push_data)
	);

	ffde_queue #(.DW(DW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_valid (qv),
		.pop_data  (pop_data)
	);

	ffde_back #(.W(W), .F(FRAC_BITS), .DW(DW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ent_valid (qv),
		.ent       (pop_data),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (back_data)
	);

	assign m_tdata = OTW'(back_data);

endmodule

// ----- verif/ffde_conserved_to_primitive_tb.sv -----
// testbench of the conserved-to-primitive converter: random and directed words, predicted results
module ffde_conserved_to_primitive_tb;
	import ffde_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WB = 48;
	localparam int SBITS = ((3 + 8 * WB + 7) / 8) * 8;
	localparam int MBITS = ((6 * WB + 2 + 7) / 8) * 8;
	localparam int N_ITEMS = 1400;
	localparam int LIMIT = 5_000_000;
	localparam int TAIL = 1300;
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_CONV = 1'b1;
	localparam logic [2:0] IDX_XX = 3'd0, IDX_XY = 3'd1, IDX_XZ = 3'd2;
	localparam logic [2:0] IDX_YY = 3'd3, IDX_YZ = 3'd4, IDX_ZZ = 3'd5;
	localparam logic [2:0] IDX_BAD6 = 3'd6, IDX_BAD7 = 3'd7;
	localparam longint WMAX = (64'sd1 <<< 47) - 1;
	localparam longint WMIN = -(64'sd1 <<< 47);
	localparam longint ONE = 64'sd1 <<< 32;
	localparam int ENTRY[3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};

	typedef struct {
		logic       cmd;
		logic [2:0] idx;
		longint     mval;
		longint     det;
		longint     cons[6];
		bit         drain;
	} word_t;

	typedef struct {
		logic [47:0] e[3];
		logic [47:0] b[3];
		status_t     st;
	} prim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [SBITS-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [MBITS-1:0] m_tdata;

	word_t pending[$];
	prim_t expected_prims[$];
	longint metric[6];
	word_t cur;
	bit busy = 0, took = 0;
	bit failed = 0;
	int unsigned cycles = 0;
	int burst_left = 0, gap_left = 0;
	int stall_mode = 0, stall_left = 0;

	ffde_conserved_to_primitive u_top (.*);

	always #6 clk = ~clk;

	// fixed-point helpers, exact products and quotients at 128 bits
	function automatic logic [127:0] magw(longint a);
		return (a < 0) ? 128'(-a) : 128'(a);
	endfunction

	function automatic longint clip(bit neg, logic [127:0] m, ref bit sat);
		logic [127:0] lim;
		lim = neg ? 128'(WMAX) + 1 : 128'(WMAX);
		if (m > lim) begin
			sat = 1;
			m = lim;
		end
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	function automatic longint fmul(longint a, longint b, ref bit sat);
		logic [127:0] m;
		m = (magw(a) * magw(b) + (128'd1 << 31)) >> 32;
		return clip((a < 0) != (b < 0), m, sat);
	endfunction

	function automatic longint fdiv(longint a, longint b, ref bit sat);
		return clip((a < 0) != (b < 0), (magw(a) << 32) / magw(b), sat);
	endfunction

	function automatic longint fsum(longint a, longint b, ref bit sat);
		longint r;
		r = a + b;
		if (r > WMAX) begin
			sat = 1;
			r = WMAX;
		end else if (r < WMIN) begin
			sat = 1;
			r = WMIN;
		end
		return r;
	endfunction

	function automatic prim_t convert_cell(word_t w);
		prim_t p;
		longint bv[3], sv[3], lo[3], q, cr;
		bit sat;
		sat = 0;
		for (int i = 0; i < 3; i++) begin
			p.e[i] = '0;
			p.b[i] = '0;
		end
		if (w.det == 0) begin
			p.st = ST_ZDET;
			return p;
		end
		for (int i = 0; i < 3; i++) begin
			bv[i] = fdiv(w.cons[i], w.det, sat);
			sv[i] = fdiv(w.cons[3+i], w.det, sat);
		end
		for (int i = 0; i < 3; i++) begin
			lo[i] = 0;
			for (int j = 0; j < 3; j++)
				lo[i] = fsum(lo[i], fmul(metric[ENTRY[i][j]], bv[j], sat), sat);
		end
		q = 0;
		for (int i = 0; i < 3; i++)
			q = fsum(q, fmul(lo[i], bv[i], sat), sat);
		for (int i = 0; i < 3; i++)
			p.b[i] = bv[i][47:0];
		if (q == 0) begin
			p.st = ST_ZQ;
			return p;
		end
		for (int i = 0; i < 3; i++) begin
			cr = fsum(fmul(lo[(i+1)%3], sv[(i+2)%3], sat),
				-fmul(lo[(i+2)%3], sv[(i+1)%3], sat), sat);
			p.e[i] = 48'(fdiv(fdiv(cr, q, sat), w.det, sat));
		end
		p.st = sat ? ST_SAT : ST_OK;
		return p;
	endfunction

	function automatic longint rnd_value();
		logic [47:0] r;
		case ($urandom_range(0, 6))
			0, 1: begin
				r = 48'({$urandom, $urandom});
				return longint'(signed'(r));
			end
			2: return longint'($urandom_range(0, 32'hFFFF_FFFF)) * 8 - (64'sd1 <<< 34);
			3: return ($urandom_range(0, 1) ? ONE : -ONE) + $urandom_range(0, 65535);
			4: return 0;
			5: return WMAX;
			default: return WMIN;
		endcase
	endfunction

	function automatic word_t mk_load(logic [2:0] idx, longint v);
		word_t w;
		w.cmd = CMD_LOAD;
		w.idx = idx;
		w.mval = v;
		w.det = rnd_value();
		foreach (w.cons[i]) w.cons[i] = rnd_value();
		w.drain = 0;
		return w;
	endfunction

	function automatic word_t mk_conv(longint det, longint b1, longint b2, longint b3,
			longint s1, longint s2, longint s3);
		word_t w;
		w.cmd = CMD_CONV;
		w.idx = 3'($urandom);
		w.mval = rnd_value();
		w.det = det;
		w.cons = '{b1, b2, b3, s1, s2, s3};
		w.drain = 0;
		return w;
	endfunction

	task automatic push_metric(bit near_flat);
		logic [2:0] idx;
		longint v;
		for (int i = 0; i < 6; i++) begin
			idx = 3'(i);
			if (near_flat)
				v = ((idx == IDX_XX || idx == IDX_YY || idx == IDX_ZZ) ? ONE : 0)
					+ longint'($urandom_range(0, 1 << 28)) - (1 << 27);
			else
				v = rnd_value();
			pending.push_back(mk_load(idx, v));
		end
	endtask

	task automatic push_rnd_conv();
		word_t w;
		w = mk_conv($urandom_range(0, 15) == 0 ? 0 : rnd_value(), rnd_value(), rnd_value(),
			rnd_value(), rnd_value(), rnd_value(), rnd_value());
		if ($urandom_range(0, 40) == 0)
			w.drain = 1;
		pending.push_back(w);
	endtask

	// stimulus
	initial begin
		word_t w;
		int n;
		// flat metric
		pending.push_back(mk_load(IDX_XX, ONE));
		pending.push_back(mk_load(IDX_XY, 0));
		pending.push_back(mk_load(IDX_XZ, 0));
		pending.push_back(mk_load(IDX_YY, ONE));
		pending.push_back(mk_load(IDX_YZ, 0));
		pending.push_back(mk_load(IDX_ZZ, ONE));
		pending.push_back(mk_conv(ONE, ONE, 2 * ONE, -ONE, ONE / 2, ONE, -3 * ONE));
		pending.push_back(mk_conv(0, ONE, ONE, ONE, ONE, ONE, ONE));
		pending.push_back(mk_conv(ONE, 0, 0, 0, ONE, ONE, ONE));
		pending.push_back(mk_conv(ONE, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN));
		pending.push_back(mk_conv(WMIN, ONE, -ONE, ONE, ONE, ONE, -ONE));
		pending.push_back(mk_conv(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX));
		pending.push_back(mk_conv(1, 1, 0, 0, 0, 1, 0));
		// dropped indexes must leave the metric untouched
		pending.push_back(mk_load(IDX_BAD6, WMAX));
		pending.push_back(mk_load(IDX_BAD7, WMIN));
		w = mk_conv(-ONE, ONE, ONE, 0, 0, ONE, ONE);
		w.drain = 1;
		pending.push_back(w);
		pending.push_back(mk_load(IDX_XY, WMIN));
		pending.push_back(mk_load(IDX_ZZ, WMAX));
		pending.push_back(mk_conv(ONE, ONE, ONE, ONE, -ONE, ONE, ONE));
		n = pending.size();
		while (n < N_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin
					pending.push_back(mk_load(3'($urandom), rnd_value()));
					n++;
				end
				1, 2, 3: begin
					push_metric($urandom_range(0, 3) != 0);
					push_rnd_conv();
					n += 7;
				end
				default: begin
					push_rnd_conv();
					n++;
				end
			endcase
		end
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		wait (pending.size() == 0 && !busy && expected_prims.size() == 0);
		repeat (TAIL) @(posedge clk);
		if (!failed)
			$display("[ffde_conserved_to_primitive] OK");
		else
			$display("[ffde_conserved_to_primitive] ERROR");
		$finish;
	end

	// sender: bursts and gaps, one nonblocking write per signal per step
	always @(negedge clk) begin
		if (arst_n) begin
			if (took)
				busy = 0;
			if (!busy) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending.size() > 0 &&
						(!pending[0].drain || expected_prims.size() == 0)) begin
					cur = pending.pop_front();
					busy = 1;
					s_tuser <= cur.cmd;
					s_tdata <= {5'b0, cur.cons[5][47:0], cur.cons[4][47:0], cur.cons[3][47:0],
						cur.cons[2][47:0], cur.cons[1][47:0], cur.cons[0][47:0],
						cur.det[47:0], cur.mval[47:0], cur.idx};
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 20);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
					end
				end
			end
			s_tvalid <= busy;
			// receiver stalls on its own pattern
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(8, 200);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 1);
				2: m_tready <= ($urandom_range(0, 7) == 0);
				default: m_tready <= (stall_left % 16) < 11;
			endcase
		end
	end

	// predict on accepted words, check every result word
	always @(posedge clk) begin
		prim_t exp_p;
		logic [47:0] act;
		cycles++;
		if (cycles > LIMIT) begin
			$display("[ffde_conserved_to_primitive] ERROR");
			$finish;
		end
		took = s_tvalid && s_tready;
		if (took) begin
			if (cur.cmd == CMD_LOAD) begin
				if (cur.idx < 3'd6)
					metric[cur.idx] = cur.mval;
			end else begin
				expected_prims.push_back(convert_cell(cur));
			end
		end
		if (m_tvalid && m_tready) begin
			if (expected_prims.size() == 0) begin
				$display("%0t unexpected word exp none got %h", $realtime, m_tdata);
				failed = 1;
			end else begin
				exp_p = expected_prims.pop_front();
				for (int i = 0; i < 6; i++) begin
					act = m_tdata[48*i +: 48];
					if (act !== (i < 3 ? exp_p.e[i] : exp_p.b[i-3])) begin
						$display("%0t field %0d exp %h got %h", $realtime, i,
							(i < 3 ? exp_p.e[i] : exp_p.b[i-3]), act);
						failed = 1;
					end
				end
				if (m_tdata[289:288] !== exp_p.st) begin
					$display("%0t status exp %0d got %0d", $realtime, exp_p.st,
						m_tdata[289:288]);
					failed = 1;
				end
			end
		end
	end

endmodule

// ----- filelist.f -----
rtl/core/ffde_pkg.sv
rtl/core/ffde_front.sv
rtl/core/ffde_queue.sv
rtl/core/ffde_alu.sv
rtl/core/ffde_back.sv
rtl/core/ffde_conserved_to_primitive.sv
verif/ffde_conserved_to_primitive_tb.sv
